// File: design/s2a_pkg.sv
`timescale 1ns / 1ps
// Shared types, scancode constants and translation tables for the scancode to ASCII block.
package s2a_pkg;

   localparam int FifoDepthDefault = 256;
   localparam int KeyCount         = 58;
   localparam int CaseGap          = 32;

   localparam logic [7:0] SC_LCTRL   = 8'h1D;
   localparam logic [7:0] SC_LSHIFT  = 8'h2A;
   localparam logic [7:0] SC_RSHIFT  = 8'h36;
   localparam logic [7:0] SC_CAPS    = 8'h3A;
   localparam logic [7:0] SC_RELEASE = 8'h80;

   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_LOWER_Z = 7'h7A;
   localparam logic [6:0] CH_LOWER_R = 7'h72;
   localparam logic [6:0] CH_UPPER_R = 7'h52;
   localparam logic [6:0] CH_LOWER_C = 7'h63;
   localparam logic [6:0] CH_UPPER_C = 7'h43;
   localparam logic [6:0] CH_LOWER_D = 7'h64;
   localparam logic [6:0] CH_UPPER_D = 7'h44;

   typedef enum logic {
      REQ_SCANCODE = 1'b0,
      REQ_READ     = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CTRL_R = 2'd1,
      EV_CTRL_C = 2'd2,
      EV_CTRL_D = 2'd3
   } ctrl_event_type;

   typedef struct packed {
      logic           char_valid;
      ctrl_event_type ctrl_event;
      logic           char_stored;
      logic           char_dropped;
      logic           dump_flag;
   } rsp_meta_type;

   function automatic logic [6:0] plain_char(input logic [5:0] idx);
      logic [6:0] ch;
      case (idx)
         6'd1:  ch = 7'h1B;
         6'd2:  ch = 7'h31;
         6'd3:  ch = 7'h32;
         6'd4:  ch = 7'h33;
         6'd5:  ch = 7'h34;
         6'd6:  ch = 7'h35;
         6'd7:  ch = 7'h36;
         6'd8:  ch = 7'h37;
         6'd9:  ch = 7'h38;
         6'd10: ch = 7'h39;
         6'd11: ch = 7'h30;
         6'd12: ch = 7'h2D;
         6'd13: ch = 7'h3D;
         6'd14: ch = 7'h08;
         6'd15: ch = 7'h09;
         6'd16: ch = 7'h71;
         6'd17: ch = 7'h77;
         6'd18: ch = 7'h65;
         6'd19: ch = 7'h72;
         6'd20: ch = 7'h74;
         6'd21: ch = 7'h79;
         6'd22: ch = 7'h75;
         6'd23: ch = 7'h69;
         6'd24: ch = 7'h6F;
         6'd25: ch = 7'h70;
         6'd26: ch = 7'h5B;
         6'd27: ch = 7'h5D;
         6'd28: ch = 7'h0A;
         6'd30: ch = 7'h61;
         6'd31: ch = 7'h73;
         6'd32: ch = 7'h64;
         6'd33: ch = 7'h66;
         6'd34: ch = 7'h67;
         6'd35: ch = 7'h68;
         6'd36: ch = 7'h6A;
         6'd37: ch = 7'h6B;
         6'd38: ch = 7'h6C;
         6'd39: ch = 7'h3B;
         6'd40: ch = 7'h27;
         6'd41: ch = 7'h60;
         6'd43: ch = 7'h5C;
         6'd44: ch = 7'h7A;
         6'd45: ch = 7'h78;
         6'd46: ch = 7'h63;
         6'd47: ch = 7'h76;
         6'd48: ch = 7'h62;
         6'd49: ch = 7'h6E;
         6'd50: ch = 7'h6D;
         6'd51: ch = 7'h2C;
         6'd52: ch = 7'h2E;
         6'd53: ch = 7'h2F;
         6'd57: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] shift_char(input logic [5:0] idx);
      logic [6:0] ch;
      case (idx)
         6'd1:  ch = 7'h1B;
         6'd2:  ch = 7'h21;
         6'd3:  ch = 7'h40;
         6'd4:  ch = 7'h23;
         6'd5:  ch = 7'h24;
         6'd6:  ch = 7'h25;
         6'd7:  ch = 7'h5E;
         6'd8:  ch = 7'h26;
         6'd9:  ch = 7'h2A;
         6'd10: ch = 7'h28;
         6'd11: ch = 7'h29;
         6'd12: ch = 7'h5F;
         6'd13: ch = 7'h2B;
         6'd14: ch = 7'h08;
         6'd15: ch = 7'h09;
         6'd16: ch = 7'h51;
         6'd17: ch = 7'h57;
         6'd18: ch = 7'h45;
         6'd19: ch = 7'h52;
         6'd20: ch = 7'h54;
         6'd21: ch = 7'h59;
         6'd22: ch = 7'h55;
         6'd23: ch = 7'h49;
         6'd24: ch = 7'h4F;
         6'd25: ch = 7'h50;
         6'd26: ch = 7'h7B;
         6'd27: ch = 7'h7D;
         6'd28: ch = 7'h0A;
         6'd30: ch = 7'h41;
         6'd31: ch = 7'h53;
         6'd32: ch = 7'h44;
         6'd33: ch = 7'h46;
         6'd34: ch = 7'h47;
         6'd35: ch = 7'h48;
         6'd36: ch = 7'h4A;
         6'd37: ch = 7'h4B;
         6'd38: ch = 7'h4C;
         6'd39: ch = 7'h3A;
         6'd40: ch = 7'h22;
         6'd41: ch = 7'h7E;
         6'd43: ch = 7'h7C;
         6'd44: ch = 7'h5A;
         6'd45: ch = 7'h58;
         6'd46: ch = 7'h43;
         6'd47: ch = 7'h56;
         6'd48: ch = 7'h42;
         6'd49: ch = 7'h4E;
         6'd50: ch = 7'h4D;
         6'd51: ch = 7'h3C;
         6'd52: ch = 7'h3E;
         6'd53: ch = 7'h3F;
         6'd57: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: design/scancode_to_ascii_with_fifo.sv
`timescale 1ns / 1ps
// Set-1 scancode to ASCII translator with a character FIFO held in a synchronous memory.
// Each item on req_ is a scancode (req_tuser = 0) or a character read (req_tuser = 1), and
// each gives exactly one item on rsp_. One item is taken per clock cycle unless rsp_tready
// back-pressure holds both stages full; the result passes through the registered read of the
// character memory and then the output register. Key flags, FIFO pointers and count sit
// in registers and update at acceptance, so a character written by one item is readable by
// the very next one. The memory needs no clearing after reset; only written entries are read.
module scancode_to_ascii_with_fifo #(
   parameter int FIFO_DEPTH = s2a_pkg::FifoDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scancode
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [6:0] char_out, [7] char_valid, [9:8] ctrl_event,
                                    // [10] char_stored, [11] char_dropped, [12] dump_flag
);

   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   logic [6:0]  mem [FIFO_DEPTH];

   logic        shift_ff, shift_in;
   logic        caps_ff, caps_in;
   logic        ctrl_ff, ctrl_in;
   logic        dump_ff, dump_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic        s1_valid_ff, s1_valid_in;
   s2a_pkg::rsp_meta_type s1_meta_ff, s1_meta_in;
   logic [6:0]  rd_data_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        accept, s1_move;
   logic        is_read, is_scan, fifo_empty, fifo_full;
   logic        do_read, do_write;
   logic [7:0]  sc;
   logic [6:0]  ch_raw, ch;
   s2a_pkg::ctrl_event_type ev;

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;
   assign is_read    = (req_tuser == s2a_pkg::REQ_READ);
   assign is_scan    = !is_read;
   assign sc         = req_tdata;
   assign fifo_empty = (count_ff == '0);
   assign fifo_full  = (count_ff == CW'(FIFO_DEPTH));

   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      ctrl_in  = ctrl_ff;
      if (accept && is_scan) begin
         if (sc == s2a_pkg::SC_LCTRL) begin
            ctrl_in = 1'b1;
         end else if (sc == (s2a_pkg::SC_LCTRL | s2a_pkg::SC_RELEASE)) begin
            ctrl_in = 1'b0;
         end else if (sc == s2a_pkg::SC_LSHIFT || sc == s2a_pkg::SC_RSHIFT) begin
            shift_in = 1'b1;
         end else if (sc == (s2a_pkg::SC_LSHIFT | s2a_pkg::SC_RELEASE) ||
                      sc == (s2a_pkg::SC_RSHIFT | s2a_pkg::SC_RELEASE)) begin
            shift_in = 1'b0;
         end else if (sc == s2a_pkg::SC_CAPS) begin
            caps_in = !caps_ff;
         end
      end
   end

   always_comb begin
      if (sc >= 8'(s2a_pkg::KeyCount)) begin
         ch_raw = 7'h00;
      end else if (shift_in) begin
         ch_raw = s2a_pkg::shift_char(sc[5:0]);
      end else begin
         ch_raw = s2a_pkg::plain_char(sc[5:0]);
      end
      if (caps_in && ch_raw >= s2a_pkg::CH_LOWER_A && ch_raw <= s2a_pkg::CH_LOWER_Z) begin
         ch = ch_raw - 7'(s2a_pkg::CaseGap);
      end else begin
         ch = ch_raw;
      end
      if (ch == s2a_pkg::CH_LOWER_R || ch == s2a_pkg::CH_UPPER_R) begin
         ev = s2a_pkg::EV_CTRL_R;
      end else if (ch == s2a_pkg::CH_LOWER_C || ch == s2a_pkg::CH_UPPER_C) begin
         ev = s2a_pkg::EV_CTRL_C;
      end else if (ch == s2a_pkg::CH_LOWER_D || ch == s2a_pkg::CH_UPPER_D) begin
         ev = s2a_pkg::EV_CTRL_D;
      end else begin
         ev = s2a_pkg::EV_NONE;
      end
   end

   always_comb begin
      do_read  = accept && is_read && !fifo_empty;
      do_write = accept && is_scan && !ctrl_in && (ch != 7'h00) && !fifo_full;

      dump_in = dump_ff;
      if (accept && is_scan && ctrl_in && ev == s2a_pkg::EV_CTRL_R) begin
         dump_in = 1'b1;
      end

      rd_ptr_in = rd_ptr_ff;
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      wr_ptr_in = wr_ptr_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_read) begin
         count_in = count_ff - 1'b1;
      end else if (do_write) begin
         count_in = count_ff + 1'b1;
      end

      s1_meta_in.char_valid   = do_read;
      s1_meta_in.ctrl_event   = (is_scan && ctrl_in) ? ev : s2a_pkg::EV_NONE;
      s1_meta_in.char_stored  = do_write;
      s1_meta_in.char_dropped = is_scan && !ctrl_in && (ch != 7'h00) && fifo_full;
      s1_meta_in.dump_flag    = dump_in;

      s1_valid_in = accept || (s1_valid_ff && !s1_move);

      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = {3'b000,
                      s1_meta_ff.dump_flag,
                      s1_meta_ff.char_dropped,
                      s1_meta_ff.char_stored,
                      s1_meta_ff.ctrl_event,
                      s1_meta_ff.char_valid,
                      s1_meta_ff.char_valid ? rd_data_ff : 7'h00};
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[wr_ptr_ff] <= ch;
      end
      if (do_read) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         ctrl_ff      <= 1'b0;
         dump_ff      <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         caps_ff      <= caps_in;
         ctrl_ff      <= ctrl_in;
         dump_ff      <= dump_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FIFO_DEPTH))
      else $error("fill count beyond depth");

   a_store_excl: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_meta_ff.char_stored && s1_meta_ff.char_dropped))
      else $error("item both stored and dropped");

   a_dump_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(dump_ff))
      else $error("dump flag cleared");

   a_write_count: assert property (@(posedge clock) disable iff (reset)
      do_write |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count not advanced on write");

   a_read_data: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_meta_ff.char_valid) |-> s1_meta_ff.ctrl_event == s2a_pkg::EV_NONE)
      else $error("read item carries an event");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-1 scancode to ASCII block with its character FIFO.
module tb;

   localparam int FifoDepth      = s2a_pkg::FifoDepthDefault;
   localparam int ItemTarget     = 1400;
   localparam int WatchdogLimit  = 2000;
   localparam int DrainCycles    = 10;
   localparam logic [7:0] KEY_R  = 8'h13;
   localparam logic [7:0] KEY_C  = 8'h2E;
   localparam logic [7:0] KEY_D  = 8'h20;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_TYPE, MODE_CTRL} traffic_mode_type;

   class keystroke_scoreboard;
      typedef struct {
         bit [6:0]                ch;
         bit                      valid;
         s2a_pkg::ctrl_event_type ev;
         bit                      stored;
         bit                      dropped;
         bit                      dump;
      } rsp_fields_type;

      bit [6:0]       plain_keys[s2a_pkg::KeyCount];
      bit [6:0]       shifted_keys[s2a_pkg::KeyCount];
      bit             shift_on, caps_lock, ctrl_on, dump_seen;
      bit [6:0]       typed_chars[$];
      rsp_fields_type pending_rsp[$];
      int             errors, checked, stored_total, dropped_total, event_total, empty_reads;

      function new();
         plain_keys = '{
            7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
            7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
            7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
            7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
            7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
            7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20};
         shifted_keys = '{
            7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
            7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
            7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
            7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
            7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
            7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20};
      endfunction

      function int level();
         return typed_chars.size();
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function bit [6:0] translate_key(logic [7:0] sc);
         bit [6:0] ch;
         if (sc >= s2a_pkg::KeyCount) return 7'h00;
         ch = shift_on ? shifted_keys[sc[5:0]] : plain_keys[sc[5:0]];
         if (caps_lock && ch >= s2a_pkg::CH_LOWER_A && ch <= s2a_pkg::CH_LOWER_Z)
            ch = ch - 7'(s2a_pkg::CaseGap);
         return ch;
      endfunction

      function void note_request(s2a_pkg::req_kind_type kind, logic [7:0] sc);
         rsp_fields_type r;
         bit [6:0]       ch;
         r = '{ch: 7'h00, valid: 1'b0, ev: s2a_pkg::EV_NONE, stored: 1'b0, dropped: 1'b0,
               dump: 1'b0};
         if (kind == s2a_pkg::REQ_READ) begin
            if (typed_chars.size() != 0) begin
               r.ch    = typed_chars.pop_front();
               r.valid = 1'b1;
            end else begin
               empty_reads++;
            end
         end else begin
            if (sc == s2a_pkg::SC_LCTRL) ctrl_on = 1'b1;
            else if (sc == (s2a_pkg::SC_LCTRL | s2a_pkg::SC_RELEASE)) ctrl_on = 1'b0;
            else if (sc == s2a_pkg::SC_LSHIFT || sc == s2a_pkg::SC_RSHIFT) shift_on = 1'b1;
            else if (sc == (s2a_pkg::SC_LSHIFT | s2a_pkg::SC_RELEASE) ||
                     sc == (s2a_pkg::SC_RSHIFT | s2a_pkg::SC_RELEASE))
               shift_on = 1'b0;
            else if (sc == s2a_pkg::SC_CAPS) caps_lock = !caps_lock;
            ch = translate_key(sc);
            if (ctrl_on) begin
               if (ch == s2a_pkg::CH_LOWER_R || ch == s2a_pkg::CH_UPPER_R) begin
                  r.ev      = s2a_pkg::EV_CTRL_R;
                  dump_seen = 1'b1;
               end else if (ch == s2a_pkg::CH_LOWER_C || ch == s2a_pkg::CH_UPPER_C) begin
                  r.ev = s2a_pkg::EV_CTRL_C;
               end else if (ch == s2a_pkg::CH_LOWER_D || ch == s2a_pkg::CH_UPPER_D) begin
                  r.ev = s2a_pkg::EV_CTRL_D;
               end
               if (r.ev != s2a_pkg::EV_NONE) event_total++;
            end else if (ch != 7'h00) begin
               if (typed_chars.size() >= FifoDepth) begin
                  r.dropped = 1'b1;
                  dropped_total++;
               end else begin
                  typed_chars.push_back(ch);
                  r.stored = 1'b1;
                  stored_total++;
               end
            end
         end
         r.dump = dump_seen;
         pending_rsp.push_back(r);
      endfunction

      function void compare(string field, logic [6:0] want, logic [6:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [15:0] tdata);
         rsp_fields_type want;
         checked++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected item, expected none, got %h", $time, tdata);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         compare("char_out", want.ch, tdata[6:0]);
         compare("char_valid", 7'(want.valid), 7'(tdata[7]));
         compare("ctrl_event", 7'(want.ev), 7'(tdata[9:8]));
         compare("char_stored", 7'(want.stored), 7'(tdata[10]));
         compare("char_dropped", 7'(want.dropped), 7'(tdata[11]));
         compare("dump_flag", 7'(want.dump), 7'(tdata[12]));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   keystroke_scoreboard sb = new();
   bit idle_in  = 1'b1;
   bit idle_out = 1'b1;
   int items_sent;
   int quiet_cycles;
   int rsp_hold;
   int rsp_hold_draw;

   scancode_to_ascii_with_fifo i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if ($urandom_range(0, 49) == 0) idle_in <= !idle_in;
      if ($urandom_range(0, 49) == 0) idle_out <= !idle_out;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_hold_draw = idle_out ? $urandom_range(0, 9) : 0;
         rsp_hold   <= rsp_hold_draw;
         rsp_tready <= (rsp_hold_draw == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold   <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input s2a_pkg::req_kind_type kind, input logic [7:0] sc);
      int gap;
      gap = idle_in ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= sc;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, sc);
      items_sent++;
   endtask

   task automatic send_random(input traffic_mode_type mode);
      int pct;
      logic [7:0] sc;
      pct = $urandom_range(0, 99);
      sc  = 8'($urandom_range(0, s2a_pkg::KeyCount - 1));
      case (mode)
         MODE_FILL: begin
            if (sc == s2a_pkg::SC_LCTRL) sc = s2a_pkg::SC_LCTRL | s2a_pkg::SC_RELEASE;
            if (pct >= 88) sc = 8'($urandom_range(128, 255));
            send_item(s2a_pkg::REQ_SCANCODE, sc);
         end
         MODE_DRAIN: begin
            if (pct < 85) send_item(s2a_pkg::REQ_READ, 8'($urandom_range(0, 255)));
            else send_item(s2a_pkg::REQ_SCANCODE, sc);
         end
         MODE_TYPE: begin
            if (pct < 20) send_item(s2a_pkg::REQ_READ, 8'($urandom_range(0, 255)));
            else if (pct < 75) send_item(s2a_pkg::REQ_SCANCODE, sc);
            else if (pct < 90)
               send_item(s2a_pkg::REQ_SCANCODE, 8'($urandom_range(128, 255)));
            else send_item(s2a_pkg::REQ_SCANCODE, 8'($urandom_range(0, 255)));
         end
         default: begin
            if (pct < 20) sc = s2a_pkg::SC_LCTRL;
            else if (pct < 30) sc = s2a_pkg::SC_LCTRL | s2a_pkg::SC_RELEASE;
            else if (pct < 65) sc = (pct < 45) ? KEY_R : (pct < 55) ? KEY_C : KEY_D;
            else if (pct < 80)
               case ($urandom_range(0, 3))
                  0: sc = s2a_pkg::SC_LSHIFT;
                  1: sc = s2a_pkg::SC_RSHIFT | s2a_pkg::SC_RELEASE;
                  2: sc = s2a_pkg::SC_LSHIFT | s2a_pkg::SC_RELEASE;
                  default: sc = s2a_pkg::SC_CAPS;
               endcase
            if (pct >= 90) send_item(s2a_pkg::REQ_READ, 8'($urandom_range(0, 255)));
            else send_item(s2a_pkg::REQ_SCANCODE, sc);
         end
      endcase
   endtask

   initial begin
      traffic_mode_type mode;
      int seg_len;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty read, plain keys, caps, shifts, ctrl events, out-of-table codes
      send_item(s2a_pkg::REQ_READ, 8'h00);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h00);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h01);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h39);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_CAPS);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h1E);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h02);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_LSHIFT);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h1E);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h02);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_LSHIFT | s2a_pkg::SC_RELEASE);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_CAPS);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_RSHIFT);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h28);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_RSHIFT | s2a_pkg::SC_RELEASE);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_LCTRL);
      send_item(s2a_pkg::REQ_SCANCODE, KEY_R);
      send_item(s2a_pkg::REQ_SCANCODE, KEY_C);
      send_item(s2a_pkg::REQ_SCANCODE, KEY_D);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h1E);
      send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_LCTRL | s2a_pkg::SC_RELEASE);
      send_item(s2a_pkg::REQ_SCANCODE, 8'hFF);
      send_item(s2a_pkg::REQ_SCANCODE, 8'h80);
      send_item(s2a_pkg::REQ_READ, 8'hFF);
      send_item(s2a_pkg::REQ_READ, 8'h55);

      // fill past full so characters drop, then drain past empty
      while (sb.level() < FifoDepth) send_random(MODE_FILL);
      repeat (40) send_random(MODE_FILL);
      while (sb.level() > 0) send_item(s2a_pkg::REQ_READ, 8'($urandom_range(0, 255)));
      repeat (15) send_item(s2a_pkg::REQ_READ, 8'($urandom_range(0, 255)));

      while (items_sent < ItemTarget) begin
         mode    = traffic_mode_type'($urandom_range(MODE_DRAIN, MODE_CTRL));
         seg_len = $urandom_range(20, 80);
         if (mode != MODE_CTRL && sb.ctrl_on)
            send_item(s2a_pkg::REQ_SCANCODE, s2a_pkg::SC_LCTRL | s2a_pkg::SC_RELEASE);
         repeat (seg_len) send_random(mode);
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("tb: %0d items sent, %0d results checked, %0d errors", items_sent, sb.checked,
               sb.errors);
      $display("tb: %0d stored, %0d dropped on full, %0d ctrl events, %0d empty reads",
               sb.stored_total, sb.dropped_total, sb.event_total, sb.empty_reads);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/s2a_pkg.sv
design/scancode_to_ascii_with_fifo.sv
verif/tb.sv
